[hdl/deq_pkg.sv]
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int OCC_W    = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic srch_first;
		logic srch_next;
		logic set_empty;
		logic set_full;
		logic take_val;
		logic take_match;
		logic emit;
	} deq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            match;
		logic            last;
		logic            out_free;
	} deq_sts_t;

endpackage

[hdl/deq_ctrl.sv]
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  deq_sts_t sts,
	output deq_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_CMP    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_DONE;
				case (sts.op)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
						end else if (sts.op == OP_PUSH_FRONT) begin
							cmd.push_front = 1'b1;
						end else begin
							cmd.push_back = 1'b1;
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
						end else begin
							cmd.pop_front = (sts.op == OP_POP_FRONT);
							cmd.pop_back  = (sts.op == OP_POP_BACK);
							state_nxt     = S_RDWAIT;
						end
					end
					OP_SEARCH: begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
						end else begin
							cmd.srch_first = 1'b1;
							state_nxt      = S_CMP;
						end
					end
					default: begin
						state_nxt = S_DONE;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.take_val = 1'b1;
				state_nxt    = S_DONE;
			end
			S_CMP: begin
				if (sts.match) begin
					cmd.take_match = 1'b1;
					state_nxt      = S_DONE;
				end else if (sts.last) begin
					state_nxt = S_DONE;
				end else begin
					cmd.srch_next = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted while output register busy");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("accepted word did not enter execution");

	a_emit_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !in_stall)
		else $error("input not released after result emitted");

endmodule

[hdl/deq_datapath.sv]
module deq_datapath
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [OP_W-1:0]            op,
	input  logic signed [VALUE_W-1:0]  value_in,
	output logic signed [VALUE_W-1:0]  value_out,
	output logic [STATUS_W-1:0]        status,
	output logic                       found,
	output logic [POS_W-1:0]           position,
	output logic [OCC_W-1:0]           occupancy,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  deq_cmd_t                   cmd,
	output deq_sts_t                   sts
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] word_in;
	logic [VALUE_W-1:0]    rd_ext;
	logic [OP_W-1:0]       op_q;
	logic [AW-1:0]         front_q;
	logic [AW-1:0]         back_q;
	logic [AW-1:0]         srch_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         k_q;

	logic [AW-1:0]         rd_addr;
	logic                  rd_en;
	logic [AW-1:0]         wr_addr;
	logic                  wr_en;

	logic [VALUE_W-1:0]    res_val_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_found_q;
	logic [CW-1:0]         res_pos_q;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_val_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_found_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [OCC_W-1:0]      out_occ_q;

	// fit the incoming word to the stored width, and the stored word back to 32 bits
	for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_win
		if (b < VALUE_W) begin : g_lo
			assign word_in[b] = value_in[b];
		end else begin : g_hi
			assign word_in[b] = value_in[VALUE_W-1];
		end
	end

	for (genvar b = 0; b < VALUE_W; b++) begin : g_rext
		if (b < DATA_WIDTH) begin : g_lo
			assign rd_ext[b] = rd_q[b];
		end else begin : g_hi
			assign rd_ext[b] = rd_q[DATA_WIDTH-1];
		end
	end

	always_comb begin
		rd_en   = cmd.pop_front | cmd.pop_back | cmd.srch_first | cmd.srch_next;
		rd_addr = front_q;
		if (cmd.pop_back) begin
			rd_addr = ring_prev(back_q);
		end else if (cmd.srch_next) begin
			rd_addr = ring_next(srch_q);
		end
		wr_en   = cmd.push_front | cmd.push_back;
		wr_addr = cmd.push_front ? ring_prev(front_q) : back_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= word_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// operand hold
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			word_q <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= ring_prev(front_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.push_back) begin
				back_q  <= ring_next(back_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop_front) begin
				front_q <= ring_next(front_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.pop_back) begin
				back_q  <= ring_prev(back_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	// search walk
	always_ff @(posedge clk) begin
		if (cmd.srch_first) begin
			srch_q <= front_q;
			k_q    <= '0;
		end else if (cmd.srch_next) begin
			srch_q <= ring_next(srch_q);
			k_q    <= k_q + 1'b1;
		end
	end

	// result build
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_val_q    <= '0;
			res_status_q <= STAT_OK;
			res_found_q  <= 1'b0;
			res_pos_q    <= '0;
		end else begin
			if (cmd.set_empty) begin
				res_status_q <= STAT_EMPTY;
			end
			if (cmd.set_full) begin
				res_status_q <= STAT_FULL;
			end
			if (cmd.take_val) begin
				res_val_q <= rd_ext;
			end
			if (cmd.take_match) begin
				res_val_q   <= rd_ext;
				res_found_q <= 1'b1;
				res_pos_q   <= k_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_val_q    <= res_val_q;
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_pos_q    <= POS_W'(res_pos_q);
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = out_val_q;
	assign status    = out_status_q;
	assign found     = out_found_q;
	assign position  = out_pos_q;
	assign occupancy = out_occ_q;

	always_comb begin
		sts.op       = op_q;
		sts.empty    = (count_q == '0);
		sts.full     = (count_q == CW'(DEPTH));
		sts.match    = (rd_q == word_q);
		sts.last     = ((k_q + 1'b1) == count_q);
		sts.out_free = !out_valid_q || !out_stall;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_front, cmd.push_back, cmd.pop_front, cmd.pop_back,
			cmd.srch_first, cmd.srch_next}))
		else $error("more than one queue access in a cycle");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not add an entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_back) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not remove an entry");

endmodule

[hdl/double_ended_queue_with_search_top.sv]
// Bounded double-ended queue of signed words with a front-to-back search. Each input word
// carries an op (push front, push back, pop front, pop back, search) and a value; each
// produces exactly one result word with the popped or matching value, a status (ok, empty,
// full with the push dropped), a found flag, the match position from the front and the
// occupancy after the op. Unused op codes are ignored and report only the occupancy.
// Entries sit in a ring memory with one read and one write port, DEPTH words of DATA_WIDTH
// bits each; narrow words are sign-extended on the way out. One word is handled at a time:
// a push runs through the idle, execute and done states; a pop adds one registered memory read
// (none when the queue is empty), and a search compares the entries from the front, one per cycle
// through the memory read port, until a match or the last one. A stalled output holds the
// result. After reset the queue is empty and ready at once; stored words are never cleared.
module double_ended_queue_with_search_top
	import deq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [OP_W-1:0]           op,
	input  logic signed [VALUE_W-1:0] value_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] value_out,
	output logic [STATUS_W-1:0]       status,
	output logic                      found,
	output logic [POS_W-1:0]          position,
	output logic [OCC_W-1:0]          occupancy
);

	// command and status between sequencer and queue datapath
	deq_cmd_t cmd;
	deq_sts_t sts;

	// sequencer: accept a word, run it, hold until the output register frees
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// ring memory, pointers, count, search walk and output register
	deq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.value_in  (value_in),
		.value_out (value_out),
		.status    (status),
		.found     (found),
		.position  (position),
		.occupancy (occupancy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[dv/deq_checker.sv]
`timescale 1ns / 1ps

module deq_checker
	import deq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [OP_W-1:0]           op,
	input  logic signed [VALUE_W-1:0] value_in,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [VALUE_W-1:0] value_out,
	input  logic [STATUS_W-1:0]       status,
	input  logic                      found,
	input  logic [POS_W-1:0]          position,
	input  logic [OCC_W-1:0]          occupancy,
	output int                        mismatches,
	output int                        outstanding
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_out;
		logic [STATUS_W-1:0]       status;
		logic                      found;
		logic [POS_W-1:0]          position;
		logic [OCC_W-1:0]          occupancy;
	} deq_result_t;

	// predicted deque contents; indices wrap at the ring size
	logic signed [VALUE_W-1:0] ring_words [DEPTH_DEF];
	logic [POS_W-1:0]          head_idx;
	logic [POS_W-1:0]          tail_idx;
	logic [OCC_W-1:0]          held;

	deq_result_t owed_results [$];
	deq_result_t due;

	function automatic deq_result_t deque_apply(input logic [OP_W-1:0] code,
		input logic signed [VALUE_W-1:0] word);
		deq_result_t      r;
		logic [POS_W-1:0] scan;
		bit               hit;
		r = '0;
		case (code)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (held >= DEPTH_DEF) begin
					r.status = STAT_FULL;
				end else if (code == OP_PUSH_FRONT) begin
					head_idx = head_idx - 1'b1;
					ring_words[head_idx] = word;
					held = held + 1'b1;
				end else begin
					ring_words[tail_idx] = word;
					tail_idx = tail_idx + 1'b1;
					held = held + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (held == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.value_out = ring_words[head_idx];
					head_idx = head_idx + 1'b1;
					held = held - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (held == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					tail_idx = tail_idx - 1'b1;
					r.value_out = ring_words[tail_idx];
					held = held - 1'b1;
				end
			end
			OP_SEARCH: begin
				if (held == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					hit = 1'b0;
					scan = head_idx;
					for (int k = 0; k < held; k++) begin
						if (!hit && ring_words[scan] == word) begin
							hit = 1'b1;
							r.found = 1'b1;
							r.position = k[POS_W-1:0];
							r.value_out = ring_words[scan];
						end
						scan = scan + 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = held;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
		input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx = '0;
			tail_idx = '0;
			held = '0;
			mismatches = 0;
			owed_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result word with no pending input word");
					mismatches++;
				end else begin
					due = owed_results.pop_front();
					check_field("value_out", due.value_out, value_out);
					check_field("status", VALUE_W'(due.status), VALUE_W'(status));
					check_field("found", VALUE_W'(due.found), VALUE_W'(found));
					check_field("position", VALUE_W'(due.position), VALUE_W'(position));
					check_field("occupancy", VALUE_W'(due.occupancy), VALUE_W'(occupancy));
				end
			end
			if (in_valid && !in_stall)
				owed_results.push_back(deque_apply(op, value_in));
			outstanding <= owed_results.size();
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	// op codes the block ignores
	localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

	localparam int RAND_ITEMS  = 1100;
	localparam int CALM_ITEMS  = 150;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 40;

	localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [OP_W-1:0]           op = OP_PUSH_FRONT;
	logic signed [VALUE_W-1:0] value_in = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] value_out;
	logic [STATUS_W-1:0]       status;
	logic                      found;
	logic [POS_W-1:0]          position;
	logic [OCC_W-1:0]          occupancy;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	// words we believe the deque holds, front first; used only to aim searches
	logic signed [VALUE_W-1:0] held_words [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	double_ended_queue_with_search_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.status    (status),
		.found     (found),
		.position  (position),
		.occupancy (occupancy)
	);

	deq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.status      (status),
		.found       (found),
		.position    (position),
		.occupancy   (occupancy),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Stall the result side in random bursts; hold it open once the run goes calm.
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one word and hold it until the block takes it. An idle burst may come
	// first, which drops valid; otherwise valid stays high straight into the
	// next word.
	task automatic send_word(input logic [OP_W-1:0] code,
		input logic signed [VALUE_W-1:0] word);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		value_in <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// track contents so that searches can aim at stored words
		case (code)
			OP_PUSH_FRONT: if (held_words.size() < DEPTH_DEF) held_words.push_front(word);
			OP_PUSH_BACK:  if (held_words.size() < DEPTH_DEF) held_words.push_back(word);
			OP_POP_FRONT:  if (held_words.size() != 0) void'(held_words.pop_front());
			OP_POP_BACK:   if (held_words.size() != 0) void'(held_words.pop_back());
			default: ;
		endcase
	endtask

	initial begin
		traffic_mode_t             mode;
		int                        phase_left;
		int                        roll;
		int                        push_pct;
		logic [OP_W-1:0]           code;
		logic signed [VALUE_W-1:0] word;

		mode = MODE_MIXED;
		phase_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-queue pops and search, ignored op codes, the extreme
		// words at both ends, search hits at both ends and a miss, then drain.
		send_word(OP_POP_FRONT, 32'sd0);
		send_word(OP_POP_BACK, 32'sd0);
		send_word(OP_SEARCH, 32'sd0);
		send_word(OP_UNUSED_LO, 32'sd0);
		send_word(OP_UNUSED_MID, WORD_MAX);
		send_word(OP_UNUSED_HI, -32'sd1);
		send_word(OP_PUSH_FRONT, WORD_MIN);
		send_word(OP_PUSH_BACK, WORD_MAX);
		send_word(OP_PUSH_BACK, 32'sd0);
		send_word(OP_PUSH_FRONT, -32'sd1);
		send_word(OP_SEARCH, 32'sd0);
		send_word(OP_SEARCH, -32'sd1);
		send_word(OP_SEARCH, 32'sd12345);
		send_word(OP_SEARCH, WORD_MIN);
		send_word(OP_UNUSED_LO, WORD_MIN);
		send_word(OP_POP_BACK, 32'sd0);
		send_word(OP_POP_FRONT, 32'sd0);
		send_word(OP_POP_FRONT, 32'sd0);
		send_word(OP_POP_BACK, 32'sd0);
		send_word(OP_POP_BACK, 32'sd0);

		// Random: phases that fill the deque to full, drain it to empty, or churn
		// in between, so wrap-around, full and empty all come up often.
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n >= RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (phase_left == 0) begin
				mode = traffic_mode_t'($urandom_range(0, 2));
				phase_left = $urandom_range(20, 60);
			end
			phase_left--;
			push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;

			// half the pushed words come from a tiny pool so duplicates show up
			word = $urandom_range(0, 1) ? VALUE_W'(int'($urandom_range(0, 7)) - 4)
				: VALUE_W'($urandom);
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				code = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			end else if (roll < 25) begin
				code = OP_SEARCH;
				// aim most searches at a stored word so hits land at every position
				if (held_words.size() != 0 && $urandom_range(0, 9) < 6)
					word = held_words[$urandom_range(0, held_words.size() - 1)];
			end else if ($urandom_range(0, 99) < push_pct) begin
				code = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			end else begin
				code = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			end
			send_word(code, word);
		end
		in_valid <= 1'b0;

		// Wait for every result, then a little longer to catch strays.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
